// File: rtl/key_press_hold_click_tracker_unit_assert.svh
// Assertion macros shared by the key press tracker RTL.
`ifndef KEY_PRESS_HOLD_CLICK_TRACKER_UNIT_ASSERT_SVH
`define KEY_PRESS_HOLD_CLICK_TRACKER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KPHC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KPHC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/kphc_pkg.sv
// Shared types and constants of the key press tracker.
`default_nettype none

package kphc_pkg;

   localparam int DEF_KEY_COUNT = 256;
   localparam int DEF_TIME_BITS = 32;

   localparam int CODE_W  = 8;
   localparam int NOW_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MS_W    = 16;
   localparam int MASK_W  = 8;

   localparam logic [MS_W-1:0]   HOLD_RESET  = 16'd800;
   localparam logic [MS_W-1:0]   CLICK_RESET = 16'd400;
   localparam logic [MASK_W-1:0] MASK_RESET  = 8'd118;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOLD  = 2'd0,
      CSR_CLICK = 2'd1,
      CSR_MASK  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_DOWN   = 2'd0,
      CMD_UP     = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      KS_NORMAL = 3'd0,
      KS_DOWN   = 3'd1,
      KS_READY  = 3'd2,
      KS_HELD   = 3'd3,
      KS_UP     = 3'd4,
      KS_CLICK  = 3'd5
   } key_state_type;

   // Everything of a table entry except its press timestamp.
   typedef struct packed {
      key_state_type state;
      logic          release_flag;
      logic          ready_flag;
      logic          rearm_flag;
   } entry_flags_type;

   localparam int FLAGS_W = $bits(entry_flags_type);

   localparam entry_flags_type FLAGS_RESET = '{
      state:        KS_NORMAL,
      release_flag: 1'b0,
      ready_flag:   1'b0,
      rearm_flag:   1'b1
   };

   // Controls for the entry update logic.
   typedef struct packed {
      cmd_type         cmd;
      logic            mouse;
      logic [MS_W-1:0] hold_ms;
      logic [MS_W-1:0] click_ms;
   } entry_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/kphc_table_ram.sv
// Key table memory: one write port, one read port with registered read data.
`default_nettype none

module kphc_table_ram #(
   parameter int DEPTH = kphc_pkg::DEF_KEY_COUNT,
   parameter int WIDTH = kphc_pkg::FLAGS_W + kphc_pkg::DEF_TIME_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/kphc_entry_next.sv
// Next value of one key table entry for a down, up, update or read command.
`default_nettype none

module kphc_entry_next #(
   parameter int TIME_BITS = kphc_pkg::DEF_TIME_BITS
) (
   input  kphc_pkg::entry_ctrl_type  ctrl,
   input  logic [TIME_BITS-1:0]      now,
   input  kphc_pkg::entry_flags_type cur_flags,
   input  logic [TIME_BITS-1:0]      cur_stamp,
   output kphc_pkg::entry_flags_type nxt_flags,
   output logic [TIME_BITS-1:0]      nxt_stamp
);

   always_comb begin
      kphc_pkg::entry_flags_type f;
      logic [TIME_BITS-1:0]      elapsed;

      f         = cur_flags;
      nxt_stamp = cur_stamp;
      elapsed   = now - cur_stamp;

      unique case (ctrl.cmd)
         kphc_pkg::CMD_DOWN: begin
            if (cur_flags.rearm_flag) begin
               nxt_stamp    = now;
               f.state      = kphc_pkg::KS_DOWN;
               f.rearm_flag = 1'b0;
            end
         end
         kphc_pkg::CMD_UP: begin
            f.state      = kphc_pkg::KS_UP;
            f.rearm_flag = 1'b1;
         end
         kphc_pkg::CMD_UPDATE: begin
            // The steps below run in order, each one seeing the previous one.
            if (cur_flags.state != kphc_pkg::KS_NORMAL) begin
               if (f.release_flag) begin
                  if (ctrl.mouse && (elapsed <= TIME_BITS'(ctrl.click_ms)) &&
                      (f.state != kphc_pkg::KS_CLICK)) begin
                     f.state = kphc_pkg::KS_CLICK;
                  end else begin
                     f.state        = kphc_pkg::KS_NORMAL;
                     f.release_flag = 1'b0;
                  end
               end
               if (f.ready_flag) begin
                  f.state      = kphc_pkg::KS_READY;
                  f.ready_flag = 1'b0;
               end
               if (f.state == kphc_pkg::KS_DOWN) begin
                  f.ready_flag = 1'b1;
               end
               if ((f.state == kphc_pkg::KS_READY) &&
                   (elapsed >= TIME_BITS'(ctrl.hold_ms))) begin
                  f.state = kphc_pkg::KS_HELD;
               end
               if (f.state == kphc_pkg::KS_UP) begin
                  f.release_flag = 1'b1;
               end
            end
         end
         kphc_pkg::CMD_READ: begin
            f = cur_flags;
         end
         default: begin
            f = cur_flags;
         end
      endcase

      nxt_flags = f;
   end

endmodule

`default_nettype wire

// File: rtl/key_press_hold_click_tracker_unit.sv
// Top level of the key press, hold and click tracker.
//
// The block keeps one table entry per key code in a single-port-write,
// single-port-read memory and answers one command per request beat.
// Request channel: req_valid/req_stall carry a command (down, up, update
// all keys, read), a key code and the current time in milliseconds.
// Response channel: rsp_valid/rsp_stall carry the addressed key's state
// after the command and whether the key is mouse-type under the mask.
// Configuration: csr_write_en writes csr_wdata into the register named by
// csr_index (hold threshold, click timeout, mouse mask); other indexes
// are ignored. Write only while the block is idle.
// Down, up and read take one memory read: the entry is read at the
// accepting edge and its data arrives in the next cycle, at the end of
// which down and up write the updated entry back. The result is then
// registered for the send state, which loads it into the output register
// once that register is free; a new request is accepted only after that.
// Update walks every entry through the memory, one entry per cycle, and
// then reaches the send state like the other commands.
// After reset the table is swept back to its reset contents, one entry per
// cycle; req_stall stays high during that sweep.
// A stalled response holds in the output register; the block may already
// accept the next request and finishes it up to the point of sending.
`default_nettype none

module key_press_hold_click_tracker_unit #(
   parameter int KEY_COUNT = kphc_pkg::DEF_KEY_COUNT,
   parameter int TIME_BITS = kphc_pkg::DEF_TIME_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_command,
   input  logic [kphc_pkg::CODE_W-1:0]     req_key_code,
   input  logic [kphc_pkg::NOW_W-1:0]      req_now_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_key_state,
   output logic                            rsp_is_mouse,
   input  logic                            csr_write_en,
   input  logic [kphc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kphc_pkg::CSR_DATA_W-1:0] csr_wdata
);

`include "key_press_hold_click_tracker_unit_assert.svh"

   localparam int IDX_W   = $clog2(KEY_COUNT);
   localparam int ENTRY_W = kphc_pkg::FLAGS_W + TIME_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_COUNT - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_SEND
   } state_type;

   // Configuration registers.
   logic [kphc_pkg::MS_W-1:0]   hold_ms_ff;
   logic [kphc_pkg::MS_W-1:0]   click_ms_ff;
   logic [kphc_pkg::MASK_W-1:0] mask_ff;

   // Sequencer state and the latched request.
   state_type                   state_ff, state_in;
   logic [IDX_W-1:0]            walk_idx_ff, walk_idx_in;
   kphc_pkg::cmd_type           cmd_ff, cmd_in;
   logic [IDX_W-1:0]            code_idx_ff, code_idx_in;
   logic                        code_valid_ff, code_valid_in;
   logic                        code_mouse_ff, code_mouse_in;
   logic [TIME_BITS-1:0]        now_ff, now_in;
   kphc_pkg::key_state_type     res_state_ff, res_state_in;

   // Output register.
   logic                        rsp_valid_ff, rsp_valid_in;
   kphc_pkg::key_state_type     rsp_state_ff, rsp_state_in;
   logic                        rsp_mouse_ff, rsp_mouse_in;

   // Memory ports and entry update.
   logic                        ram_we;
   logic [IDX_W-1:0]            ram_waddr;
   logic [ENTRY_W-1:0]          ram_wdata;
   logic                        ram_re;
   logic [IDX_W-1:0]            ram_raddr;
   logic [ENTRY_W-1:0]          ram_rdata;
   kphc_pkg::entry_ctrl_type    upd_ctrl;
   kphc_pkg::entry_flags_type   cur_flags, nxt_flags;
   logic [TIME_BITS-1:0]        cur_stamp, nxt_stamp;
   logic                        walk_mouse;
   logic                        req_accept;
   logic                        send_go;

   assign req_accept = req_valid && !req_stall;
   assign send_go    = (state_ff == S_SEND) && (!rsp_valid_ff || !rsp_stall);

   // Configuration writes; only the listed indexes have a register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ms_ff  <= kphc_pkg::HOLD_RESET;
         click_ms_ff <= kphc_pkg::CLICK_RESET;
         mask_ff     <= kphc_pkg::MASK_RESET;
      end else if (csr_write_en) begin
         if (csr_index == kphc_pkg::CSR_HOLD) begin
            hold_ms_ff <= csr_wdata;
         end
         if (csr_index == kphc_pkg::CSR_CLICK) begin
            click_ms_ff <= csr_wdata;
         end
         if (csr_index == kphc_pkg::CSR_MASK) begin
            mask_ff <= csr_wdata[kphc_pkg::MASK_W-1:0];
         end
      end
   end

   // Entry being processed comes straight from the memory read register.
   assign cur_flags  = kphc_pkg::entry_flags_type'(ram_rdata[ENTRY_W-1:TIME_BITS]);
   assign cur_stamp  = ram_rdata[TIME_BITS-1:0];

   // Only key codes 0 to 7 can be mouse-type.
   assign walk_mouse = ((walk_idx_ff >> 3) == '0) && mask_ff[walk_idx_ff[2:0]];

   always_comb begin
      upd_ctrl.cmd      = cmd_ff;
      upd_ctrl.mouse    = walk_mouse;
      upd_ctrl.hold_ms  = hold_ms_ff;
      upd_ctrl.click_ms = click_ms_ff;
   end

   kphc_entry_next #(
      .TIME_BITS(TIME_BITS)
   ) u_entry_next (
      .ctrl      (upd_ctrl),
      .now       (now_ff),
      .cur_flags (cur_flags),
      .cur_stamp (cur_stamp),
      .nxt_flags (nxt_flags),
      .nxt_stamp (nxt_stamp)
   );

   kphc_table_ram #(
      .DEPTH(KEY_COUNT),
      .WIDTH(ENTRY_W)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Sequencer: next state, memory port control and result capture.
   always_comb begin
      state_in      = state_ff;
      walk_idx_in   = walk_idx_ff;
      cmd_in        = cmd_ff;
      code_idx_in   = code_idx_ff;
      code_valid_in = code_valid_ff;
      code_mouse_in = code_mouse_ff;
      now_in        = now_ff;
      res_state_in  = res_state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_state_in  = rsp_state_ff;
      rsp_mouse_in  = rsp_mouse_ff;
      req_stall     = (state_ff != S_IDLE);
      ram_we        = 1'b0;
      ram_waddr     = walk_idx_ff;
      ram_wdata     = {nxt_flags, nxt_stamp};
      ram_re        = 1'b0;
      ram_raddr     = walk_idx_ff + IDX_W'(1);

      unique case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_wdata = {kphc_pkg::FLAGS_RESET, {TIME_BITS{1'b0}}};
            if (walk_idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               walk_idx_in = walk_idx_ff + IDX_W'(1);
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               cmd_in        = kphc_pkg::cmd_type'(req_command);
               code_idx_in   = IDX_W'(req_key_code);
               code_valid_in = (32'(req_key_code) < 32'(KEY_COUNT));
               code_mouse_in = (req_key_code < 8'd8) && mask_ff[req_key_code[2:0]];
               now_in        = TIME_BITS'(req_now_ms);
               res_state_in  = kphc_pkg::KS_NORMAL;
               walk_idx_in   = '0;
               ram_re        = 1'b1;
               if (kphc_pkg::cmd_type'(req_command) == kphc_pkg::CMD_UPDATE) begin
                  ram_raddr = '0;
                  state_in  = S_WALK;
               end else begin
                  ram_raddr = IDX_W'(req_key_code);
                  state_in  = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            ram_waddr = code_idx_ff;
            ram_we    = code_valid_ff &&
                        ((cmd_ff == kphc_pkg::CMD_DOWN) || (cmd_ff == kphc_pkg::CMD_UP));
            res_state_in = code_valid_ff ? nxt_flags.state : kphc_pkg::KS_NORMAL;
            state_in     = S_SEND;
         end
         S_WALK: begin
            // Write back entry walk_idx while reading the one after it.
            ram_we = 1'b1;
            if (code_valid_ff && (walk_idx_ff == code_idx_ff)) begin
               res_state_in = nxt_flags.state;
            end
            if (walk_idx_ff == LAST_IDX) begin
               state_in = S_SEND;
            end else begin
               ram_re      = 1'b1;
               walk_idx_in = walk_idx_ff + IDX_W'(1);
            end
         end
         S_SEND: begin
            if (send_go) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = res_state_ff;
               rsp_mouse_in = code_mouse_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         walk_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_idx_ff  <= walk_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      code_idx_ff   <= code_idx_in;
      code_valid_ff <= code_valid_in;
      code_mouse_ff <= code_mouse_in;
      now_ff        <= now_in;
      res_state_ff  <= res_state_in;
      rsp_state_ff  <= rsp_state_in;
      rsp_mouse_ff  <= rsp_mouse_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_state = rsp_state_ff;
   assign rsp_is_mouse  = rsp_mouse_ff;

   `KPHC_ASSERT_NOW(a_clear_blocks_req, clock, reset, state_ff == S_CLEAR, req_stall,
      "request accepted during table clear")
   `KPHC_ASSERT_NOW(a_no_write_when_quiet, clock, reset,
      (state_ff == S_IDLE) || (state_ff == S_SEND), !ram_we,
      "table written outside clear, execute or walk")
   `KPHC_ASSERT_NEXT(a_send_loads_rsp, clock, reset, send_go, rsp_valid_ff,
      "response not loaded after send")
   `KPHC_ASSERT_NOW(a_rsp_state_legal, clock, reset, rsp_valid_ff,
      rsp_state_ff <= kphc_pkg::KS_CLICK, "response carries an undefined key state")

endmodule

`default_nettype wire
